// ===== rtl/core/modular_exponentiation_defines.svh =====
// assertion macros for the modular exponentiation block
// expects clk and rst_n in the scope where a macro is used
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication
`define ME_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant out of reset
`define ME_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== rtl/core/me_pkg.sv =====
// shared types, constants and microcode table of the modular exponentiation block
// no dependencies
package me_pkg;

    localparam int OPERAND_WIDTH_DEF = 31;

    // configuration port
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    // addend select of the modular multiplier
    localparam logic [1:0] BSEL_ONE  = 2'd0;
    localparam logic [1:0] BSEL_ACC  = 2'd1;
    localparam logic [1:0] BSEL_BASE = 2'd2;

    // jump conditions
    localparam logic [1:0] JC_NONE    = 2'd0;
    localparam logic [1:0] JC_BIT_CLR = 2'd1;
    localparam logic [1:0] JC_CNT_NZ  = 2'd2;

    // program steps
    localparam int PC_WIDTH = 3;
    localparam logic [PC_WIDTH-1:0] STEP_REDUCE = 3'd0;
    localparam logic [PC_WIDTH-1:0] STEP_SQUARE = 3'd1;
    localparam logic [PC_WIDTH-1:0] STEP_TEST   = 3'd2;
    localparam logic [PC_WIDTH-1:0] STEP_MULT   = 3'd3;
    localparam logic [PC_WIDTH-1:0] STEP_NEXT   = 3'd4;
    localparam logic [PC_WIDTH-1:0] STEP_DONE   = 3'd5;

    typedef struct packed {
        logic                mm_op;
        logic                a_acc;
        logic [1:0]          b_sel;
        logic                dst_acc;
        logic [1:0]          jcond;
        logic [PC_WIDTH-1:0] target;
        logic                cnt_dec;
        logic                done;
    } uword_t;

    typedef struct packed {
        logic       load;
        logic       mm_start;
        logic       mm_write;
        logic       a_acc;
        logic [1:0] b_sel;
        logic       dst_acc;
        logic       cnt_dec;
    } ctrl_t;

    typedef struct packed {
        logic mm_done;
        logic exp_bit;
        logic cnt_zero;
    } stat_t;

    function automatic uword_t ucode_rom(input logic [PC_WIDTH-1:0] pc);
        uword_t w;
        w = '0;
        unique case (pc)
            STEP_REDUCE:
            begin
                w.mm_op   = 1'b1;
                w.b_sel   = BSEL_ONE;
            end
            STEP_SQUARE:
            begin
                w.mm_op   = 1'b1;
                w.a_acc   = 1'b1;
                w.b_sel   = BSEL_ACC;
                w.dst_acc = 1'b1;
            end
            STEP_TEST:
            begin
                w.jcond   = JC_BIT_CLR;
                w.target  = STEP_NEXT;
            end
            STEP_MULT:
            begin
                w.mm_op   = 1'b1;
                w.a_acc   = 1'b1;
                w.b_sel   = BSEL_BASE;
                w.dst_acc = 1'b1;
            end
            STEP_NEXT:
            begin
                w.cnt_dec = 1'b1;
                w.jcond   = JC_CNT_NZ;
                w.target  = STEP_SQUARE;
            end
            STEP_DONE:
            begin
                w.done    = 1'b1;
            end
            default:
            begin
                w.done    = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/me_base_if.sv =====
// input channel carrying one base value per transaction
// depends on me_pkg
interface me_base_if #(
    parameter int OPERAND_WIDTH = me_pkg::OPERAND_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink (input valid, input base_value, output ready);
endinterface

// ===== rtl/core/me_result_if.sv =====
// output channel carrying one power result per transaction
// depends on me_pkg
interface me_result_if #(
    parameter int OPERAND_WIDTH = me_pkg::OPERAND_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

// ===== rtl/core/me_mmul.sv =====
// bit-serial modular multiplier, one bit of the scanned operand per cycle
// depends on me_pkg; addend and running remainder stay below the modulus
module me_mmul #(
    parameter int OPERAND_WIDTH = me_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] a,
    input  logic [OPERAND_WIDTH-1:0] b,
    input  logic [OPERAND_WIDTH-1:0] m,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int TW = W + 2;
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  m_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [TW-1:0] t;
    logic [TW:0]   d1, d2;

    // r = 2r + a_bit*b, then fold back below m (t < 3m)
    always_comb
    begin
        t  = {1'b0, r_reg, 1'b0} + (a_reg[W-1] ? TW'(b_reg) : TW'(0));
        d1 = {1'b0, t} - {3'b000, m_reg};
        d2 = {1'b0, t} - {2'b00, m_reg, 1'b0};
        if (!d2[TW])
            r_next = d2[W-1:0];
        else if (!d1[TW])
            r_next = d1[W-1:0];
        else
            r_next = t[W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
            busy_next = 1'b1;
        else if (busy_reg && cnt_reg == '0)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= '0;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            cnt_reg <= CW'(W - 1);
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            a_reg   <= {a_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ===== rtl/core/me_dp.sv =====
// datapath: base and accumulator registers, exponent bit counter, modular multiplier
// depends on me_pkg and me_mmul
module me_dp #(
    parameter int OPERAND_WIDTH = me_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  me_pkg::ctrl_t            ctrl,
    output me_pkg::stat_t            stat,
    input  logic [OPERAND_WIDTH-1:0] base_value,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    input  logic [OPERAND_WIDTH-1:0] exponent,
    output logic [OPERAND_WIDTH-1:0] acc
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  base_reg;
    logic [W-1:0]  acc_reg;
    logic [CW-1:0] cnt_reg;

    logic [W-1:0]  mm_a, mm_b, mm_result;
    logic          mm_done;

    always_comb
    begin
        mm_a = ctrl.a_acc ? acc_reg : base_reg;
        unique case (ctrl.b_sel)
            me_pkg::BSEL_ONE:  mm_b = W'(1);
            me_pkg::BSEL_ACC:  mm_b = acc_reg;
            me_pkg::BSEL_BASE: mm_b = base_reg;
            default:           mm_b = W'(1);
        endcase
    end

    me_mmul #(
        .OPERAND_WIDTH(W)
    ) u_mmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (modulus),
        .done   (mm_done),
        .result (mm_result)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            base_reg <= base_value;
            acc_reg  <= W'(1);
            cnt_reg  <= CW'(W - 1);
        end
        else
        begin
            if (ctrl.mm_write)
            begin
                if (ctrl.dst_acc)
                    acc_reg <= mm_result;
                else
                    base_reg <= mm_result;
            end
            if (ctrl.cnt_dec && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign stat.mm_done  = mm_done;
    assign stat.exp_bit  = exponent[cnt_reg];
    assign stat.cnt_zero = (cnt_reg == '0);
    assign acc           = acc_reg;

endmodule

// ===== rtl/core/me_seq.sv =====
// microcode sequencer: step counter, table fetch, multiplier handshake, jumps
// depends on me_pkg
module me_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          out_free,
    input  me_pkg::stat_t stat,
    output me_pkg::ctrl_t ctrl,
    output logic          busy,
    output logic          out_load
);

    logic [me_pkg::PC_WIDTH-1:0] pc_reg, pc_next;
    logic                        busy_reg, busy_next;
    logic                        wait_reg, wait_next;
    me_pkg::uword_t              uword;
    logic                        advance;
    logic                        take;

    assign uword = me_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (uword.jcond)
            me_pkg::JC_NONE:    take = 1'b0;
            me_pkg::JC_BIT_CLR: take = !stat.exp_bit;
            me_pkg::JC_CNT_NZ:  take = !stat.cnt_zero;
            default:            take = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        pc_next   = pc_reg;
        busy_next = busy_reg;
        wait_next = wait_reg;
        out_load  = 1'b0;
        advance   = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                ctrl.load = 1'b1;
                busy_next = 1'b1;
                pc_next   = me_pkg::STEP_REDUCE;
                wait_next = 1'b0;
            end
        end
        else
        begin
            ctrl.a_acc   = uword.a_acc;
            ctrl.b_sel   = uword.b_sel;
            ctrl.dst_acc = uword.dst_acc;
            if (uword.mm_op)
            begin
                if (!wait_reg)
                begin
                    ctrl.mm_start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (stat.mm_done)
                begin
                    ctrl.mm_write = 1'b1;
                    wait_next     = 1'b0;
                    advance       = 1'b1;
                end
            end
            else if (uword.done)
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    busy_next = 1'b0;
                end
            end
            else
                advance = 1'b1;

            if (advance)
            begin
                ctrl.cnt_dec = uword.cnt_dec;
                pc_next      = take ? uword.target : pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= me_pkg::STEP_REDUCE;
            busy_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            wait_reg <= wait_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// top level of the modular exponentiation block: config registers, channels, result register
// depends on me_pkg, me_base_if, me_result_if, me_seq, me_dp
//
// Computes power_result = base_value ^ exponent mod modulus for each input transaction,
// with modulus and exponent held in two APB-writable registers (modulus at byte 0, exponent
// at byte 4, reset values 1 and 0). A modulus of 0 or 1 gives 0. The work is a square and
// multiply scan over all OPERAND_WIDTH exponent bits, from the top bit down, run by a
// six-step microcode program. Each modular product goes through one bit-serial multiplier
// that folds one bit of its operand per cycle, and that multiplier sets the rate. One
// transaction is in work at a time; the next base is accepted as soon as the previous result
// sits in the output register, even if that result has not been taken yet. Write the
// registers only while idle.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = me_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    me_base_if.sink                        operand,
    me_result_if.source                    result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [me_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [me_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [me_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                           pready
);

    localparam int W = OPERAND_WIDTH;

    // configuration registers
    logic [W-1:0] modulus_reg;
    logic [W-1:0] exponent_reg;
    logic         cfg_write;
    logic         reg_sel;

    // output register
    logic         result_valid_reg, result_valid_next;
    logic [W-1:0] result_data_reg;

    // control between sequencer and datapath
    me_pkg::ctrl_t ctrl;
    me_pkg::stat_t stat;
    logic          busy;
    logic          out_free;
    logic          out_load;
    logic [W-1:0]  acc;
    logic          mod_small;

    // APB: zero wait states, register picked by the word address bit
    assign pready    = 1'b1;
    assign reg_sel   = paddr[me_pkg::PADDR_WIDTH-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= W'(1);
            exponent_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (reg_sel == me_pkg::REG_MODULUS)
                modulus_reg <= pwdata[W-1:0];
            else
                exponent_reg <= pwdata[W-1:0];
        end
    end

    assign prdata = (reg_sel == me_pkg::REG_EXPONENT) ? me_pkg::PDATA_WIDTH'(exponent_reg)
                                                      : me_pkg::PDATA_WIDTH'(modulus_reg);

    // a modulus of 0 or 1 forces a zero result, the program still runs its course
    assign mod_small = (modulus_reg <= W'(1));

    // input side is free whenever no transaction is in work
    assign operand.ready = !busy;

    // result register frees up in the same cycle it is taken
    assign out_free = !result_valid_reg || result.ready;

    me_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (operand.valid && operand.ready),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .out_load (out_load)
    );

    me_dp #(
        .OPERAND_WIDTH(W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .base_value (operand.base_value),
        .modulus    (modulus_reg),
        .exponent   (exponent_reg),
        .acc        (acc)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
            result_valid_next = 1'b1;
        else if (result.ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            result_data_reg <= mod_small ? '0 : acc;
    end

    assign result.valid        = result_valid_reg;
    assign result.power_result = result_data_reg;

endmodule

// ===== rtl/core/me_checker.sv =====
// port-level checks of the modular exponentiation block, bound to the top level
// depends on modular_exponentiation_defines.svh
`include "modular_exponentiation_defines.svh"

module me_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic pready
);

    // a pending result holds until taken
    `ME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before taken")

    // an accepted transaction holds input ready low in the following cycle
    `ME_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // a new result only comes out of a transaction in work
    `ME_ASSERT_IMPLY(a_result_from_work, $rose(out_valid), !$past(in_ready), "result while idle")

    // config port never stalls
    `ME_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind modular_exponentiation me_checker u_me_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .pready    (pready)
);
